/* rtl/core/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BDTE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// property checked at every clock edge, reset included
`define BDTE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/bdte_pkg.sv */
// types, codes and calendar helpers for the date/time editor
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package bdte_pkg;

    localparam logic [11:0] BASE_YEAR = 12'd2000;
    localparam logic [11:0] LAST_YEAR = 12'd2099;
    localparam logic [6:0]  YEAR_OFF_MAX = 7'd99;

    // key codes
    localparam logic [1:0] KEY_UP    = 2'd0;
    localparam logic [1:0] KEY_DN    = 2'd1;
    localparam logic [1:0] KEY_SEL   = 2'd2;
    localparam logic [1:0] KEY_OTHER = 2'd3;

    // press kinds
    localparam logic [1:0] PRESS_SHORT  = 2'd0;
    localparam logic [1:0] PRESS_REPEAT = 2'd1;
    localparam logic [1:0] PRESS_OTHER  = 2'd2;

    // focus positions
    localparam logic [2:0] FOCUS_BACK   = 3'd0;
    localparam logic [2:0] FOCUS_YEAR   = 3'd1;
    localparam logic [2:0] FOCUS_MONTH  = 3'd2;
    localparam logic [2:0] FOCUS_DAY    = 3'd3;
    localparam logic [2:0] FOCUS_HOUR   = 3'd4;
    localparam logic [2:0] FOCUS_MINUTE = 3'd5;
    localparam logic [2:0] FOCUS_SECOND = 3'd6;

    // field limits
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    // state after reset: 2024-01-01 00:00:00
    localparam logic [6:0] START_YEAR_OFF = 7'd24;
    localparam logic [3:0] START_MONTH    = 4'd1;
    localparam logic [4:0] START_DAY      = 5'd1;
    localparam logic [4:0] START_HOUR     = 5'd0;
    localparam logic [5:0] START_MINUTE   = 6'd0;
    localparam logic [5:0] START_SECOND   = 6'd0;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  key_code;
        logic [1:0]  press_kind;
        logic [11:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } t_req;

    typedef struct packed {
        logic [6:0] year;     // offset from 2000
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       edit;
        logic [2:0] focus;
    } t_dt_state;

    typedef struct packed {
        t_dt_state state;
        logic      commit;
        logic      leave;
    } t_step_res;

    // month length; offsets stay in 0..99, so every fourth year is leap (2000 too)
    function automatic logic [4:0] days_of(input logic [6:0] yoff, input logic [3:0] mon);
        logic       leap;
        logic [4:0] d;
        leap = (yoff[1:0] == 2'b00);
        unique case (mon)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] clamp_day(input logic [4:0] d, input logic [4:0] lim);
        logic [4:0] r;
        if (d > lim) begin
            r = lim;
        end else if (d == 5'd0) begin
            r = 5'd1;
        end else begin
            r = d;
        end
        return r;
    endfunction

    // +1 or -1 inside [lo, hi] with wrap
    function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] lo,
                                             input logic [6:0] hi, input logic up);
        logic [6:0] r;
        if (up) begin
            r = (v >= hi) ? lo : v + 7'd1;
        end else begin
            r = (v <= lo) ? hi : v - 7'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bdte_if.sv */
// request and response channel interfaces of the date/time editor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bdte_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [1:0]  key_code;
    logic [1:0]  press_kind;
    logic [11:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;

    modport source (
        output valid, req_type, key_code, press_kind, load_year, load_month,
               load_day, load_hour, load_minute, load_second,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_code, press_kind, load_year, load_month,
               load_day, load_hour, load_minute, load_second,
        output ready
    );
endinterface

interface bdte_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic        edit_mode;
    logic [2:0]  focus_pos;
    logic        commit_pulse;
    logic        leave_pulse;

    modport source (
        output valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
               edit_mode, focus_pos, commit_pulse, leave_pulse,
        input  ready
    );
    modport sink (
        input  valid, cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
               edit_mode, focus_pos, commit_pulse, leave_pulse,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/bdte_next.sv */
// next-state logic of the date/time editor for one request beat
// depends on bdte_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdte_next
    import bdte_pkg::*;
(
    input  t_dt_state i_state,
    input  t_req      i_item,
    output t_step_res o_res
);

    logic [6:0] w_ld_year;
    logic [3:0] w_ld_month;
    logic [6:0] w_step;
    logic       w_up;
    logic       w_take;
    logic [4:0] w_dim;

    // load path: saturate the year and month into range
    always_comb begin
        if (i_item.load_year < BASE_YEAR) begin
            w_ld_year = 7'd0;
        end else if (i_item.load_year > LAST_YEAR) begin
            w_ld_year = YEAR_OFF_MAX;
        end else begin
            w_ld_year = 7'(i_item.load_year - BASE_YEAR);
        end
        if (i_item.load_month == 4'd0) begin
            w_ld_month = 4'd1;
        end else if (i_item.load_month > MONTH_MAX) begin
            w_ld_month = MONTH_MAX;
        end else begin
            w_ld_month = i_item.load_month;
        end
    end

    assign w_up   = (i_item.key_code == KEY_UP);
    assign w_take = (i_item.press_kind == PRESS_SHORT) ||
                    ((i_item.press_kind == PRESS_REPEAT) &&
                     ((i_item.key_code == KEY_UP) || (i_item.key_code == KEY_DN)));
    assign w_dim  = days_of(i_state.year, i_state.month);

    // wrapped step of the focused field
    always_comb begin
        unique case (i_state.focus)
            FOCUS_YEAR:   w_step = wrap_step(i_state.year, 7'd0, YEAR_OFF_MAX, w_up);
            FOCUS_MONTH:  w_step = wrap_step({3'd0, i_state.month}, 7'd1,
                                             {3'd0, MONTH_MAX}, w_up);
            FOCUS_DAY:    w_step = wrap_step({2'd0, i_state.day}, 7'd1, {2'd0, w_dim}, w_up);
            FOCUS_HOUR:   w_step = wrap_step({2'd0, i_state.hour}, 7'd0,
                                             {2'd0, HOUR_MAX}, w_up);
            FOCUS_MINUTE: w_step = wrap_step({1'b0, i_state.minute}, 7'd0,
                                             {1'b0, MINUTE_MAX}, w_up);
            FOCUS_SECOND: w_step = wrap_step({1'b0, i_state.second}, 7'd0,
                                             {1'b0, MINUTE_MAX}, w_up);
            default:      w_step = 7'd0;
        endcase
    end

    always_comb begin
        o_res        = '0;
        o_res.state  = i_state;
        if (i_item.req_type) begin
            o_res.state.year   = w_ld_year;
            o_res.state.month  = w_ld_month;
            o_res.state.day    = clamp_day(i_item.load_day, days_of(w_ld_year, w_ld_month));
            o_res.state.hour   = (i_item.load_hour > HOUR_MAX) ? HOUR_MAX : i_item.load_hour;
            o_res.state.minute = (i_item.load_minute > MINUTE_MAX) ? MINUTE_MAX
                                                                    : i_item.load_minute;
            o_res.state.second = (i_item.load_second > MINUTE_MAX) ? MINUTE_MAX
                                                                    : i_item.load_second;
            o_res.state.edit   = 1'b0;
            o_res.state.focus  = FOCUS_BACK;
        end else if (i_state.edit) begin
            if (w_take) begin
                unique case (i_item.key_code)
                    KEY_UP, KEY_DN: begin
                        unique case (i_state.focus)
                            FOCUS_YEAR: begin
                                o_res.state.year = w_step;
                                o_res.state.day  = clamp_day(i_state.day,
                                                       days_of(w_step, i_state.month));
                            end
                            FOCUS_MONTH: begin
                                o_res.state.month = w_step[3:0];
                                o_res.state.day   = clamp_day(i_state.day,
                                                        days_of(i_state.year, w_step[3:0]));
                            end
                            FOCUS_DAY:    o_res.state.day    = w_step[4:0];
                            FOCUS_HOUR:   o_res.state.hour   = w_step[4:0];
                            FOCUS_MINUTE: o_res.state.minute = w_step[5:0];
                            FOCUS_SECOND: o_res.state.second = w_step[5:0];
                            default: ;
                        endcase
                    end
                    KEY_SEL: begin
                        o_res.state.edit = 1'b0;
                        o_res.commit     = 1'b1;
                    end
                    default: ;
                endcase
            end
        end else if (i_item.press_kind == PRESS_SHORT) begin
            unique case (i_item.key_code)
                KEY_UP: begin
                    o_res.state.focus = (i_state.focus == FOCUS_BACK) ? FOCUS_SECOND
                                                                      : i_state.focus - 3'd1;
                end
                KEY_DN: begin
                    o_res.state.focus = (i_state.focus >= FOCUS_SECOND) ? FOCUS_BACK
                                                                        : i_state.focus + 3'd1;
                end
                KEY_SEL: begin
                    if (i_state.focus == FOCUS_BACK) begin
                        o_res.leave = 1'b1;
                    end else begin
                        o_res.state.edit = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/button_date_time_editor.sv */
// Three-button date/time editor. Each request beat is either a key event
// (up, down, enter, other; short, auto-repeat or other press) or a load of the
// current clock time, and each one yields exactly one response beat with the
// edited date/time, the navigate/edit mode, the focus (0 back, 1..6 year to
// second) and the commit and leave pulses. The block takes one request beat per
// clock cycle unless the response side stalls. Each request passes through the two registers
// of the datapath in order: the request register and the response register, with the
// calendar step in between.
// Request ready follows response ready combinationally, and a request is still
// taken while a finished response waits on the output, if the request register is empty.
// depends on bdte_pkg, bdte_if and bdte_next
`timescale 1ns / 1ps
`default_nettype none

module button_date_time_editor
    import bdte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdte_req_if.sink   i_req,
    bdte_rsp_if.source o_rsp
);

    // request register
    logic      r_in_valid;
    t_req      r_in;
    // editor state
    t_dt_state r_state;
    // response register
    logic      r_out_valid;
    t_step_res r_res;

    t_step_res n_res;
    logic      w_adv;
    logic      w_take_in;

    // request moves on when the response slot is empty or being drained
    assign w_adv     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_take_in = i_req.valid && i_req.ready;

    // calendar and menu step for the beat in the request register
    bdte_next u_next (
        .i_state (r_state),
        .i_item  (r_in),
        .o_res   (n_res)
    );

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in.req_type    <= i_req.req_type;
            r_in.key_code    <= i_req.key_code;
            r_in.press_kind  <= i_req.press_kind;
            r_in.load_year   <= i_req.load_year;
            r_in.load_month  <= i_req.load_month;
            r_in.load_day    <= i_req.load_day;
            r_in.load_hour   <= i_req.load_hour;
            r_in.load_minute <= i_req.load_minute;
            r_in.load_second <= i_req.load_second;
        end
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    // control and editor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state.year   <= START_YEAR_OFF;
            r_state.month  <= START_MONTH;
            r_state.day    <= START_DAY;
            r_state.hour   <= START_HOUR;
            r_state.minute <= START_MINUTE;
            r_state.second <= START_SECOND;
            r_state.edit   <= 1'b0;
            r_state.focus  <= FOCUS_BACK;
        end else begin
            if (w_take_in) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                // state commits only when the beat leaves for the output
                r_state     <= n_res.state;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response beat
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.cur_year     = BASE_YEAR + {5'd0, r_res.state.year};
    assign o_rsp.cur_month    = r_res.state.month;
    assign o_rsp.cur_day      = r_res.state.day;
    assign o_rsp.cur_hour     = r_res.state.hour;
    assign o_rsp.cur_minute   = r_res.state.minute;
    assign o_rsp.cur_second   = r_res.state.second;
    assign o_rsp.edit_mode    = r_res.state.edit;
    assign o_rsp.focus_pos    = r_res.state.focus;
    assign o_rsp.commit_pulse = r_res.commit;
    assign o_rsp.leave_pulse  = r_res.leave;

endmodule

`default_nettype wire

/* rtl/core/bdte_checker.sv */
// port-level checks of the date/time editor, bound to the top level
// depends on assert_macros.svh and bdte_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bdte_checker
    import bdte_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [11:0] i_cur_year,
    input logic [3:0]  i_cur_month,
    input logic [4:0]  i_cur_day,
    input logic        i_edit_mode,
    input logic [2:0]  i_focus_pos,
    input logic        i_commit_pulse,
    input logic        i_leave_pulse
);

    // a waiting response beat holds its payload
    `BDTE_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_cur_day) && $stable(i_focus_pos)), "response changed while stalled")

    // calendar fields stay in range
    `BDTE_ASSERT(a_date_range, i_clk, i_rst_n, i_out_valid |-> ((i_cur_year >= BASE_YEAR) && (i_cur_year <= LAST_YEAR) && (i_cur_month != 4'd0) && (i_cur_month <= MONTH_MAX) && (i_cur_day != 5'd0)), "date out of range")

    // editing always sits on a field, never on back
    `BDTE_ASSERT(a_edit_focus, i_clk, i_rst_n, (i_out_valid && i_edit_mode) |-> ((i_focus_pos != FOCUS_BACK) && (i_focus_pos <= FOCUS_SECOND)), "edit mode without field")

    // pulses only in navigate mode, leave only on back
    `BDTE_ASSERT(a_pulses, i_clk, i_rst_n, (i_out_valid && (i_commit_pulse || i_leave_pulse)) |-> (!i_edit_mode && !(i_commit_pulse && i_leave_pulse) && (!i_leave_pulse || (i_focus_pos == FOCUS_BACK))), "bad pulse combination")

endmodule

bind button_date_time_editor bdte_checker u_bdte_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_cur_year     (o_rsp.cur_year),
    .i_cur_month    (o_rsp.cur_month),
    .i_cur_day      (o_rsp.cur_day),
    .i_edit_mode    (o_rsp.edit_mode),
    .i_focus_pos    (o_rsp.focus_pos),
    .i_commit_pulse (o_rsp.commit_pulse),
    .i_leave_pulse  (o_rsp.leave_pulse)
);

`default_nettype wire

/* test/bdte_result_checker.sv */
// result checker for the date/time editor testbench: watches both channels,
// predicts every response beat and compares it field by field
// depends on bdte_pkg and bdte_if
`timescale 1ns / 1ps

module bdte_result_checker
    import bdte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bdte_req_if  i_req,
    bdte_rsp_if  i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_commits,
    output int   o_leaves
);

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        edit;
        logic [2:0]  focus;
        logic        commit;
        logic        leave;
    } t_editor_view;

    localparam int PRINT_LIMIT = 200;

    // predicted editor views, oldest first
    t_editor_view due_views[$];

    // predicted calendar and cursor
    logic [6:0] cal_year;
    logic [3:0] cal_month;
    logic [4:0] cal_day;
    logic [4:0] cal_hour;
    logic [5:0] cal_minute;
    logic [5:0] cal_second;
    logic       cal_edit;
    logic [2:0] cal_focus;

    int n_errors  = 0;
    int n_checked = 0;
    int n_commits = 0;
    int n_leaves  = 0;

    function automatic logic [4:0] month_length(input logic [6:0] yoff, input logic [3:0] mon);
        int unsigned yr;
        bit          leap;
        yr = BASE_YEAR + yoff;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mon)
            4'd2:                    return leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default:                 return 5'd31;
        endcase
    endfunction

    function automatic logic [4:0] fit_day(input int unsigned d, input logic [6:0] yoff,
                                           input logic [3:0] mon);
        int unsigned lim;
        lim = month_length(yoff, mon);
        if (d > lim) return 5'(lim);
        if (d == 0) return 5'd1;
        return 5'(d);
    endfunction

    function automatic int unsigned stepped(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi, input bit up);
        if (up) return (v >= hi) ? lo : v + 1;
        return (v <= lo) ? hi : v - 1;
    endfunction

    // advance the predicted editor by one request beat
    function automatic t_editor_view step_editor(input t_req r);
        t_editor_view v;
        int unsigned  yr;
        bit           up;
        logic         commit;
        logic         leave;
        commit = 1'b0;
        leave  = 1'b0;
        up     = (r.key_code == KEY_UP);
        if (r.req_type) begin
            yr = r.load_year;
            if (yr < BASE_YEAR) yr = BASE_YEAR;
            if (yr > LAST_YEAR) yr = LAST_YEAR;
            cal_year   = 7'(yr - BASE_YEAR);
            cal_month  = (r.load_month == 4'd0) ? 4'd1 :
                         (r.load_month > MONTH_MAX) ? MONTH_MAX : r.load_month;
            cal_day    = fit_day(r.load_day, cal_year, cal_month);
            cal_hour   = (r.load_hour > HOUR_MAX) ? HOUR_MAX : r.load_hour;
            cal_minute = (r.load_minute > MINUTE_MAX) ? MINUTE_MAX : r.load_minute;
            cal_second = (r.load_second > MINUTE_MAX) ? MINUTE_MAX : r.load_second;
            cal_edit   = 1'b0;
            cal_focus  = FOCUS_BACK;
        end else if (cal_edit) begin
            if (r.press_kind == PRESS_SHORT ||
                (r.press_kind == PRESS_REPEAT &&
                 (r.key_code == KEY_UP || r.key_code == KEY_DN))) begin
                if (r.key_code == KEY_SEL) begin
                    cal_edit = 1'b0;
                    commit   = 1'b1;
                end else if (r.key_code != KEY_OTHER) begin
                    case (cal_focus)
                        FOCUS_YEAR: begin
                            cal_year = 7'(stepped(cal_year, 0, YEAR_OFF_MAX, up));
                            cal_day  = fit_day(cal_day, cal_year, cal_month);
                        end
                        FOCUS_MONTH: begin
                            cal_month = 4'(stepped(cal_month, 1, MONTH_MAX, up));
                            cal_day   = fit_day(cal_day, cal_year, cal_month);
                        end
                        FOCUS_DAY:
                            cal_day = 5'(stepped(cal_day, 1,
                                                 month_length(cal_year, cal_month), up));
                        FOCUS_HOUR:   cal_hour   = 5'(stepped(cal_hour, 0, HOUR_MAX, up));
                        FOCUS_MINUTE: cal_minute = 6'(stepped(cal_minute, 0, MINUTE_MAX, up));
                        FOCUS_SECOND: cal_second = 6'(stepped(cal_second, 0, MINUTE_MAX, up));
                        default: ;
                    endcase
                end
            end
        end else if (r.press_kind == PRESS_SHORT) begin
            case (r.key_code)
                KEY_UP:
                    cal_focus = (cal_focus == FOCUS_BACK) ? FOCUS_SECOND : cal_focus - 3'd1;
                KEY_DN:
                    cal_focus = (cal_focus >= FOCUS_SECOND) ? FOCUS_BACK : cal_focus + 3'd1;
                KEY_SEL: begin
                    if (cal_focus == FOCUS_BACK) leave = 1'b1;
                    else cal_edit = 1'b1;
                end
                default: ;
            endcase
        end
        v.year   = BASE_YEAR + cal_year;
        v.month  = cal_month;
        v.day    = cal_day;
        v.hour   = cal_hour;
        v.minute = cal_minute;
        v.second = cal_second;
        v.edit   = cal_edit;
        v.focus  = cal_focus;
        v.commit = commit;
        v.leave  = leave;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("response %0d %s = %0d, expected %0d",
                                      n_checked, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_editor_view got;
        t_editor_view want;
        t_req         beat;
        if (!i_rst_n) begin
            cal_year   = START_YEAR_OFF;
            cal_month  = START_MONTH;
            cal_day    = START_DAY;
            cal_hour   = START_HOUR;
            cal_minute = START_MINUTE;
            cal_second = START_SECOND;
            cal_edit   = 1'b0;
            cal_focus  = FOCUS_BACK;
            due_views.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.year   = i_rsp.cur_year;
                got.month  = i_rsp.cur_month;
                got.day    = i_rsp.cur_day;
                got.hour   = i_rsp.cur_hour;
                got.minute = i_rsp.cur_minute;
                got.second = i_rsp.cur_second;
                got.edit   = i_rsp.edit_mode;
                got.focus  = i_rsp.focus_pos;
                got.commit = i_rsp.commit_pulse;
                got.leave  = i_rsp.leave_pulse;
                if (due_views.size() == 0) begin
                    report_mismatch("response beat with no request waiting for it");
                end else begin
                    want = due_views.pop_front();
                    check_field("cur_year", got.year, want.year);
                    check_field("cur_month", got.month, want.month);
                    check_field("cur_day", got.day, want.day);
                    check_field("cur_hour", got.hour, want.hour);
                    check_field("cur_minute", got.minute, want.minute);
                    check_field("cur_second", got.second, want.second);
                    check_field("edit_mode", got.edit, want.edit);
                    check_field("focus_pos", got.focus, want.focus);
                    check_field("commit_pulse", got.commit, want.commit);
                    check_field("leave_pulse", got.leave, want.leave);
                    n_checked++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                beat.req_type    = i_req.req_type;
                beat.key_code    = i_req.key_code;
                beat.press_kind  = i_req.press_kind;
                beat.load_year   = i_req.load_year;
                beat.load_month  = i_req.load_month;
                beat.load_day    = i_req.load_day;
                beat.load_hour   = i_req.load_hour;
                beat.load_minute = i_req.load_minute;
                beat.load_second = i_req.load_second;
                want = step_editor(beat);
                if (want.commit) n_commits++;
                if (want.leave) n_leaves++;
                due_views.push_back(want);
            end
        end
        o_errors  <= n_errors;
        o_pending <= due_views.size();
        o_checked <= n_checked;
        o_commits <= n_commits;
        o_leaves  <= n_leaves;
    end

endmodule

/* test/tb_button_date_time_editor.sv */
// top of the date/time editor testbench: clock, reset, request stimulus,
// response backpressure and the verdict
// depends on bdte_pkg, bdte_if, button_date_time_editor and bdte_result_checker
`timescale 1ns / 1ps

module tb_button_date_time_editor;
    import bdte_pkg::*;

    logic clk;
    logic rst_n;

    // per-cycle idle chances in percent, changed per phase
    int send_idle_pct;
    int rcv_idle_pct;

    int n_beats;
    int n_loads;

    // focus the editor sits on while in navigate mode, as far as stimulus knows it
    logic [2:0] cursor;

    int errors;
    int pending;
    int checked;
    int commits;
    int leaves;

    bdte_req_if req_ch ();
    bdte_rsp_if rsp_ch ();

    button_date_time_editor u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bdte_result_checker u_check (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_ch),
        .i_rsp     (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked),
        .o_commits (commits),
        .o_leaves  (leaves)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // response backpressure: one decision per cycle
    always @(posedge clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // key event; the load fields carry random bits the block must ignore
    function automatic t_req key_beat(input logic [1:0] key, input logic [1:0] kind);
        t_req r;
        r.req_type    = 1'b0;
        r.key_code    = key;
        r.press_kind  = kind;
        r.load_year   = 12'($urandom_range(4095));
        r.load_month  = 4'($urandom_range(15));
        r.load_day    = 5'($urandom_range(31));
        r.load_hour   = 5'($urandom_range(31));
        r.load_minute = 6'($urandom_range(63));
        r.load_second = 6'($urandom_range(63));
        return r;
    endfunction

    // clock time load; key fields are random and must be ignored
    function automatic t_req clock_beat(input int yr, input int mo, input int dy,
                                        input int hr, input int mi, input int se);
        t_req r;
        r.req_type    = 1'b1;
        r.key_code    = 2'($urandom_range(3));
        r.press_kind  = 2'($urandom_range(3));
        r.load_year   = 12'(yr);
        r.load_month  = 4'(mo);
        r.load_day    = 5'(dy);
        r.load_hour   = 5'(hr);
        r.load_minute = 6'(mi);
        r.load_second = 6'(se);
        return r;
    endfunction

    // one request beat: random idle cycles first, then hold until accepted
    task automatic push_beat(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.req_type;
        req_ch.key_code    <= r.key_code;
        req_ch.press_kind  <= r.press_kind;
        req_ch.load_year   <= r.load_year;
        req_ch.load_month  <= r.load_month;
        req_ch.load_day    <= r.load_day;
        req_ch.load_hour   <= r.load_hour;
        req_ch.load_minute <= r.load_minute;
        req_ch.load_second <= r.load_second;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        n_beats++;
        if (r.req_type) begin
            n_loads++;
            cursor = FOCUS_BACK;
        end
    endtask

    // stop sending and wait for every predicted response to arrive
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // random clock load: mostly legal times with month-end days, some wild values
    task automatic random_load();
        if ($urandom_range(4) == 0) begin
            push_beat(clock_beat($urandom_range(1) ? $urandom_range(4095) :
                                 $urandom_range(1990, 2110),
                                 $urandom_range(15), $urandom_range(31),
                                 $urandom_range(31), $urandom_range(63), $urandom_range(63)));
        end else begin
            push_beat(clock_beat($urandom_range(2000, 2099), $urandom_range(1, 12),
                                 $urandom_range(1) ? $urandom_range(28, 31) :
                                 $urandom_range(1, 31),
                                 $urandom_range(23), $urandom_range(59), $urandom_range(59)));
        end
    endtask

    // move the focus in navigate mode to a given position, either direction
    task automatic walk_to(input logic [2:0] target);
        int downs;
        downs = (int'(target) + 7 - int'(cursor)) % 7;
        if ($urandom_range(1)) begin
            repeat (downs) push_beat(key_beat(KEY_DN, PRESS_SHORT));
        end else begin
            repeat ((7 - downs) % 7) push_beat(key_beat(KEY_UP, PRESS_SHORT));
        end
        cursor = target;
    endtask

    // one random scenario; most are full edit sessions with random content
    task automatic run_scenario();
        int          pick;
        int          presses;
        bit          dir_up;
        logic [2:0]  field;
        logic [1:0]  side_key;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // noise: random keys and press kinds, then a load to regain the cursor
            repeat ($urandom_range(1, 6)) begin
                push_beat(key_beat(2'($urandom_range(3)), 2'($urandom_range(3))));
            end
            random_load();
        end else if (pick < 20) begin
            random_load();
        end else if (pick < 28) begin
            // leave request from the back item
            walk_to(FOCUS_BACK);
            push_beat(key_beat(KEY_SEL, PRESS_SHORT));
        end else begin
            field = 3'($urandom_range(FOCUS_YEAR, FOCUS_SECOND));
            walk_to(field);
            push_beat(key_beat(KEY_SEL, PRESS_SHORT));
            // long runs push the field through its wrap
            presses = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
            dir_up  = 1'($urandom_range(1));
            repeat (presses) begin
                side_key = $urandom_range(1) ? KEY_UP : KEY_DN;
                case ($urandom_range(24))
                    0: push_beat(key_beat(KEY_SEL, PRESS_REPEAT));
                    1: push_beat(key_beat(KEY_OTHER, 2'($urandom_range(3))));
                    2: push_beat(key_beat(side_key, 2'($urandom_range(PRESS_OTHER, 3))));
                    3, 4, 5, 6: push_beat(key_beat(side_key, PRESS_SHORT));
                    default: push_beat(key_beat(dir_up ? KEY_UP : KEY_DN,
                                                $urandom_range(1) ? PRESS_SHORT : PRESS_REPEAT));
                endcase
            end
            // commit; editor drops back to navigate on the same field
            push_beat(key_beat(KEY_SEL, PRESS_SHORT));
        end
    endtask

    initial begin
        int target;
        rst_n               = 1'b0;
        send_idle_pct       = 0;
        rcv_idle_pct        = 0;
        n_beats             = 0;
        n_loads             = 0;
        cursor              = FOCUS_BACK;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = 1'b0;
        req_ch.key_code     = KEY_UP;
        req_ch.press_kind   = PRESS_SHORT;
        req_ch.load_year    = '0;
        req_ch.load_month   = '0;
        req_ch.load_day     = '0;
        req_ch.load_hour    = '0;
        req_ch.load_minute  = '0;
        req_ch.load_second  = '0;
        rsp_ch.ready        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, light idling on both sides
        send_idle_pct = 26;
        rcv_idle_pct  = 55;

        // focus wraps both ways from the back item, enter there asks to leave
        push_beat(key_beat(KEY_UP, PRESS_SHORT));
        push_beat(key_beat(KEY_DN, PRESS_SHORT));
        push_beat(key_beat(KEY_SEL, PRESS_SHORT));
        // navigate ignores the other key, auto-repeat and long presses
        push_beat(key_beat(KEY_OTHER, PRESS_SHORT));
        push_beat(key_beat(KEY_UP, PRESS_REPEAT));
        push_beat(key_beat(KEY_UP, PRESS_OTHER));
        push_beat(key_beat(KEY_DN, 2'd3));
        // loads saturate every field high, then low
        push_beat(clock_beat(4095, 15, 31, 31, 63, 63));
        push_beat(clock_beat(0, 0, 0, 0, 0, 0));
        // feb 31 of a leap year clamps to the 29th
        push_beat(clock_beat(2000, 2, 31, 12, 30, 30));
        // edit the year: wrap down to 2099 clamps the day to 28, repeat-up wraps back
        push_beat(key_beat(KEY_DN, PRESS_SHORT));
        push_beat(key_beat(KEY_SEL, PRESS_SHORT));
        push_beat(key_beat(KEY_DN, PRESS_SHORT));
        push_beat(key_beat(KEY_UP, PRESS_REPEAT));
        // edit mode ignores auto-repeat enter, the other key and long presses
        push_beat(key_beat(KEY_SEL, PRESS_REPEAT));
        push_beat(key_beat(KEY_OTHER, PRESS_SHORT));
        push_beat(key_beat(KEY_UP, PRESS_OTHER));
        push_beat(key_beat(KEY_SEL, PRESS_SHORT));
        // day field: step down and commit
        push_beat(key_beat(KEY_DN, PRESS_SHORT));
        push_beat(key_beat(KEY_DN, PRESS_SHORT));
        push_beat(key_beat(KEY_SEL, PRESS_SHORT));
        push_beat(key_beat(KEY_DN, PRESS_SHORT));
        push_beat(key_beat(KEY_SEL, PRESS_SHORT));
        cursor = FOCUS_DAY;
        // sender holds off until the editor has answered everything
        drain_results();

        // random part in three idling phases
        target = n_beats + 385;
        while (n_beats < target) run_scenario();
        drain_results();

        send_idle_pct = 55;
        rcv_idle_pct  = 26;
        target = n_beats + 385;
        while (n_beats < target) run_scenario();
        drain_results();

        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        target = n_beats + 385;
        while (n_beats < target) run_scenario();
        drain_results();

        // two-stage datapath; waiting on after the drain catches stray responses
        repeat (8) @(posedge clk);

        $display("covered %0d request beats (%0d clock loads) under three idling mixes",
                 n_beats, n_loads);
        $display("checked %0d responses, %0d commits and %0d leave requests among them",
                 checked, commits, leaves);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
